>>> hdl/reversing_motor_cycle_sequencer_defines.svh
// Assertion macros shared by the reversing motor cycle sequencer RTL.
`ifndef REVERSING_MOTOR_CYCLE_SEQUENCER_DEFINES_SVH
`define REVERSING_MOTOR_CYCLE_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define RMCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/rmcs_pkg.sv
// Types and constants shared by the reversing motor cycle sequencer modules.
`timescale 1ns / 1ps
`default_nettype none
package rmcs_pkg;

  localparam logic [9:0] DEBOUNCE_MS     = 10'd500;
  localparam logic [7:0] REFRESH_MS      = 8'd250;
  localparam logic [7:0] RAMP_INCREMENT  = 8'd10;
  localparam logic       START_DIRECTION = 1'b0;

  // mA = floor(d * 5000000 / 1024 / 140) = floor(d * 15625 / 448), done as a
  // multiply by a rounded-up reciprocal scaled by 2^20; exact for d < 5461.
  localparam int         SENSE_W   = 10;
  localparam int         MULT_W    = 26;
  localparam int         CUR_FRAC  = 20;
  localparam int         CUR_W     = 16;
  localparam logic [MULT_W-1:0] CUR_MULT = 26'd36571429;

  // Configuration register indexes.
  localparam logic [2:0] REG_SPEED_DUTY     = 3'd0;
  localparam logic [2:0] REG_FORWARD_RUN    = 3'd1;
  localparam logic [2:0] REG_REVERSE_RUN    = 3'd2;
  localparam logic [2:0] REG_PAUSE          = 3'd3;
  localparam logic [2:0] REG_CYCLE_TARGET   = 3'd4;
  localparam logic [2:0] REG_CLEAR_ON_PAUSE = 3'd5;
  localparam logic [2:0] REG_RAMP_STEP      = 3'd6;
  localparam logic [2:0] REG_SENSE_OFFSET   = 3'd7;

  typedef struct packed {
    logic [7:0]  speed_duty;
    logic [15:0] forward_run_ms;
    logic [15:0] reverse_run_ms;
    logic [15:0] pause_ms;
    logic [7:0]  cycle_target;
    logic        clear_on_pause;
    logic [7:0]  ramp_step_ms;
    logic [9:0]  sense_offset;
  } cfg_regs_t;

  typedef struct packed {
    logic        button_pressed;
    logic [9:0]  sense_sample;
  } tick_item_t;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic        drive_a;
    logic        drive_b;
    logic        direction_led;
    logic        motor_running;
    logic [15:0] current_ma;
    logic        current_update;
    logic [8:0]  half_turn_count;
    logic        sequence_enabled;
    logic        finished;
  } tick_result_t;

endpackage
`default_nettype wire

>>> hdl/reversing_motor_cycle_sequencer.sv
// Top level of the reversing motor cycle sequencer: stream ports, tick and result registers.
`timescale 1ns / 1ps
`default_nettype none
// Each input word is one 1 ms tick carrying the button level and a current-sense sample;
// each tick yields exactly one result word with the PWM duty, bridge lines, status flags,
// half-turn count and the latest motor current in mA. The block accepts one tick word per
// clock and gives one result word per clock while the sink keeps taking them: the tick is
// captured in an input register, the whole sequencer update (debounce, phase machine, soft
// start, and the single constant multiply that scales current to mA) is done in one pass,
// and the result is held in an output register until the sink takes it. A stalled output
// holds both registers, so at most two words are in flight. Configuration writes are
// always accepted (cfg_ready is tied high) and take effect on the next tick; write them
// only while no tick is in flight. After reset the motor is stopped and the sequence is
// disabled; a debounced button press starts it.
module reversing_motor_cycle_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] button_pressed, [10:1] sense_sample, [15:11] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] pwm_duty, [8] drive_a, [9] drive_b, [10] direction_led, [11] motor_running,
  // [27:12] current_ma, [28] current_update, [37:29] half_turn_count,
  // [38] sequence_enabled, [39] finished
  output logic      [39:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  rmcs_pkg::cfg_regs_t    cfg;
  rmcs_pkg::tick_item_t   tick_r;
  rmcs_pkg::tick_result_t result;

  logic        tick_valid_r, tick_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_word_r;
  logic        in_accept;
  logic        step;

  assign cfg_ready = 1'b1;

  rmcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A held tick is processed when the output register is empty or being drained.
  assign step      = tick_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !tick_valid_r || step;
  assign in_accept = in_tvalid && in_tready;

  rmcs_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (tick_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    tick_valid_nxt = tick_valid_r;
    if (in_accept) begin
      tick_valid_nxt = 1'b1;
    end else if (step) begin
      tick_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r.button_pressed <= in_tdata[0];
      tick_r.sense_sample   <= in_tdata[10:1];
    end
    if (step) begin
      out_word_r <= {result.finished, result.sequence_enabled, result.half_turn_count,
                     result.current_update, result.current_ma, result.motor_running,
                     result.direction_led, result.drive_b, result.drive_a,
                     result.pwm_duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

endmodule
`default_nettype wire

>>> hdl/rmcs_cfg_regs.sv
// Configuration register file with its reset values.
`timescale 1ns / 1ps
`default_nettype none
module rmcs_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [2:0]        wr_index,
  input  wire logic [15:0]       wr_data,
  output rmcs_pkg::cfg_regs_t    cfg
);

  rmcs_pkg::cfg_regs_t cfg_r;
  rmcs_pkg::cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        rmcs_pkg::REG_SPEED_DUTY:     cfg_nxt.speed_duty     = wr_data[7:0];
        rmcs_pkg::REG_FORWARD_RUN:    cfg_nxt.forward_run_ms = wr_data;
        rmcs_pkg::REG_REVERSE_RUN:    cfg_nxt.reverse_run_ms = wr_data;
        rmcs_pkg::REG_PAUSE:          cfg_nxt.pause_ms       = wr_data;
        rmcs_pkg::REG_CYCLE_TARGET:   cfg_nxt.cycle_target   = wr_data[7:0];
        rmcs_pkg::REG_CLEAR_ON_PAUSE: cfg_nxt.clear_on_pause = wr_data[0];
        rmcs_pkg::REG_RAMP_STEP:      cfg_nxt.ramp_step_ms   = wr_data[7:0];
        rmcs_pkg::REG_SENSE_OFFSET:   cfg_nxt.sense_offset   = wr_data[9:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_duty     <= 8'd255;
      cfg_r.forward_run_ms <= 16'd5000;
      cfg_r.reverse_run_ms <= 16'd5000;
      cfg_r.pause_ms       <= 16'd4000;
      cfg_r.cycle_target   <= 8'd5;
      cfg_r.clear_on_pause <= 1'b0;
      cfg_r.ramp_step_ms   <= 8'd2;
      cfg_r.sense_offset   <= 10'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hdl/rmcs_sense_scale.sv
// Converts an offset-corrected current-sense sample to milliamps.
`timescale 1ns / 1ps
`default_nettype none
module rmcs_sense_scale (
  input  wire logic [rmcs_pkg::SENSE_W-1:0] sample,
  input  wire logic [rmcs_pkg::SENSE_W-1:0] offset,
  output logic      [rmcs_pkg::CUR_W-1:0]   current_ma
);

  logic [rmcs_pkg::SENSE_W-1:0]                  delta;
  logic [rmcs_pkg::SENSE_W+rmcs_pkg::MULT_W-1:0] product;

  // Readings at or below the zero-current offset count as no current.
  assign delta   = (sample > offset) ? (sample - offset) : '0;
  assign product = {{rmcs_pkg::MULT_W{1'b0}}, delta} *
                   {{rmcs_pkg::SENSE_W{1'b0}}, rmcs_pkg::CUR_MULT};
  assign current_ma = product[rmcs_pkg::CUR_FRAC +: rmcs_pkg::CUR_W];

endmodule
`default_nettype wire

>>> hdl/rmcs_seq_core.sv
// Per-tick sequencing state machine: debounce, half-turn phases and current refresh.
`timescale 1ns / 1ps
`default_nettype none
`include "reversing_motor_cycle_sequencer_defines.svh"
module rmcs_seq_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire rmcs_pkg::tick_item_t   item,
  input  wire rmcs_pkg::cfg_regs_t    cfg,
  output rmcs_pkg::tick_result_t      result
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PAUSE    = 3'd1,
    PH_RAMP     = 3'd2,
    PH_RUN      = 3'd3,
    PH_FINISHED = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic        enabled_r, enabled_nxt;
  logic [9:0]  debounce_r, debounce_nxt;
  logic [7:0]  refresh_r, refresh_nxt;
  logic [15:0] phase_timer_r, phase_timer_nxt;
  logic        turn_expired_r, turn_expired_nxt;
  logic [7:0]  duty_r, duty_nxt;
  logic [7:0]  ramp_timer_r, ramp_timer_nxt;
  logic        direction_r, direction_nxt;
  logic [9:0]  turn_count_r, turn_count_nxt;
  logic [15:0] current_r, current_nxt;
  logic        pin_a_r, pin_a_nxt;
  logic        pin_b_r, pin_b_nxt;
  logic        pin_led_r, pin_led_nxt;

  logic [7:0]  pwm;
  logic        update;
  logic [15:0] run_time;
  logic [8:0]  ramp_sum;
  logic [15:0] sense_ma;

  rmcs_sense_scale u_scale (
    .sample     (item.sense_sample),
    .offset     (cfg.sense_offset),
    .current_ma (sense_ma)
  );

  assign run_time  = direction_r ? cfg.forward_run_ms : cfg.reverse_run_ms;
  assign ramp_sum  = {1'b0, duty_r} + {1'b0, rmcs_pkg::RAMP_INCREMENT};
  assign phase_cur = (phase_r == PH_FINISHED && item.button_pressed) ? PH_IDLE : phase_r;

  always_comb begin
    phase_nxt        = phase_cur;
    enabled_nxt      = enabled_r;
    debounce_nxt     = debounce_r;
    refresh_nxt      = refresh_r;
    phase_timer_nxt  = phase_timer_r;
    turn_expired_nxt = turn_expired_r;
    duty_nxt         = duty_r;
    ramp_timer_nxt   = ramp_timer_r;
    direction_nxt    = direction_r;
    turn_count_nxt   = turn_count_r;
    current_nxt      = current_r;
    pin_a_nxt        = pin_a_r;
    pin_b_nxt        = pin_b_r;
    pin_led_nxt      = pin_led_r;
    pwm              = '0;
    update           = 1'b0;

    if (debounce_r < rmcs_pkg::DEBOUNCE_MS) debounce_nxt = debounce_r + 10'd1;
    if (refresh_r < rmcs_pkg::REFRESH_MS) refresh_nxt = refresh_r + 8'd1;

    unique case (phase_cur) inside
      PH_IDLE, PH_RUN: begin
        if (item.button_pressed && debounce_nxt >= rmcs_pkg::DEBOUNCE_MS) begin
          enabled_nxt  = ~enabled_r;
          debounce_nxt = '0;
        end
        if (refresh_nxt >= rmcs_pkg::REFRESH_MS) begin
          refresh_nxt = '0;
          if (phase_cur == PH_RUN) begin
            current_nxt = sense_ma;
            update      = 1'b1;
          end
        end
        if (phase_timer_r != 16'hFFFF) phase_timer_nxt = phase_timer_r + 16'd1;
        if (enabled_nxt && (turn_count_r[9:1] <= {1'b0, cfg.cycle_target})) begin
          if (turn_expired_r || phase_timer_nxt >= run_time) begin
            // End of a half turn (or the dummy one on the first enabled tick).
            phase_nxt        = PH_IDLE;
            phase_timer_nxt  = '0;
            turn_expired_nxt = 1'b0;
            direction_nxt    = ~direction_r;
            turn_count_nxt   = turn_count_r + 10'd1;
          end else if (phase_cur == PH_IDLE) begin
            if (turn_count_r != 10'd2 && cfg.pause_ms != 16'd0) begin
              phase_nxt       = PH_PAUSE;
              phase_timer_nxt = '0;
            end else begin
              pin_a_nxt      = direction_r;
              pin_b_nxt      = ~direction_r;
              pin_led_nxt    = direction_r;
              duty_nxt       = '0;
              ramp_timer_nxt = '0;
              phase_nxt      = PH_RAMP;
            end
          end else begin
            pwm = duty_r;
          end
        end else begin
          phase_nxt = PH_IDLE;
          if (cfg.clear_on_pause) turn_count_nxt = '0;
          if (turn_count_nxt[9:1] > {1'b0, cfg.cycle_target}) begin
            enabled_nxt      = 1'b0;
            turn_count_nxt   = 10'd1;
            turn_expired_nxt = 1'b1;
            direction_nxt    = ~direction_r;
            phase_nxt        = PH_FINISHED;
          end else begin
            pin_a_nxt = 1'b1;
            pin_b_nxt = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        if (phase_timer_r != 16'hFFFF) phase_timer_nxt = phase_timer_r + 16'd1;
        if (phase_timer_nxt >= cfg.pause_ms) begin
          pin_a_nxt      = direction_r;
          pin_b_nxt      = ~direction_r;
          pin_led_nxt    = direction_r;
          duty_nxt       = '0;
          ramp_timer_nxt = '0;
          phase_nxt      = PH_RAMP;
        end
      end
      PH_RAMP: begin
        if (ramp_timer_r != 8'd0) ramp_timer_nxt = ramp_timer_r - 8'd1;
        if (ramp_timer_nxt == 8'd0) begin
          if (ramp_sum <= {1'b0, cfg.speed_duty}) begin
            duty_nxt       = ramp_sum[7:0];
            ramp_timer_nxt = cfg.ramp_step_ms;
          end else begin
            duty_nxt        = cfg.speed_duty;
            phase_nxt       = PH_RUN;
            phase_timer_nxt = '0;
          end
        end
        pwm = duty_nxt;
      end
      PH_FINISHED: begin
        phase_nxt = PH_FINISHED;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      enabled_r      <= 1'b0;
      debounce_r     <= rmcs_pkg::DEBOUNCE_MS;
      refresh_r      <= '0;
      phase_timer_r  <= '0;
      turn_expired_r <= 1'b1;
      duty_r         <= '0;
      ramp_timer_r   <= '0;
      direction_r    <= rmcs_pkg::START_DIRECTION;
      turn_count_r   <= 10'd1;
      current_r      <= '0;
      pin_a_r        <= 1'b0;
      pin_b_r        <= 1'b0;
      pin_led_r      <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      enabled_r      <= enabled_nxt;
      debounce_r     <= debounce_nxt;
      refresh_r      <= refresh_nxt;
      phase_timer_r  <= phase_timer_nxt;
      turn_expired_r <= turn_expired_nxt;
      duty_r         <= duty_nxt;
      ramp_timer_r   <= ramp_timer_nxt;
      direction_r    <= direction_nxt;
      turn_count_r   <= turn_count_nxt;
      current_r      <= current_nxt;
      pin_a_r        <= pin_a_nxt;
      pin_b_r        <= pin_b_nxt;
      pin_led_r      <= pin_led_nxt;
    end
  end

  always_comb begin
    result.pwm_duty         = pwm;
    result.drive_a          = pin_a_nxt;
    result.drive_b          = pin_b_nxt;
    result.direction_led    = pin_led_nxt;
    result.motor_running    = (phase_nxt == PH_RUN);
    result.current_ma       = current_nxt;
    result.current_update   = update;
    result.half_turn_count  = turn_count_nxt[9] ? 9'h1FF : turn_count_nxt[8:0];
    result.sequence_enabled = enabled_nxt;
    result.finished         = (phase_nxt == PH_FINISHED);
  end

  `RMCS_ASSERT_IMPLY(a_finished_disabled, clk, rst_n, phase_r == PH_FINISHED, !enabled_r,
                     "sequencer finished but still enabled")
  `RMCS_ASSERT_IMPLY(a_run_drives_bridge, clk, rst_n, phase_r == PH_RUN, pin_a_r != pin_b_r,
                     "motor runs with bridge braked")
  `RMCS_ASSERT_IMPLY(a_debounce_bound, clk, rst_n, 1'b1, debounce_r <= rmcs_pkg::DEBOUNCE_MS,
                     "debounce counter past its period")
  `RMCS_ASSERT_IMPLY(a_refresh_bound, clk, rst_n, 1'b1, refresh_r <= rmcs_pkg::REFRESH_MS,
                     "refresh counter past its period")
  `RMCS_ASSERT_NEXT(a_hold_without_step, clk, rst_n, !step,
                    $stable(turn_count_r) && $stable(phase_r), "state moved without a tick")

endmodule
`default_nettype wire
